[design/dual_hash_64_lookup2_djb2_unit_defines.svh]
// assertion macros for the dual lookup2 / djb2 hash unit
`ifndef DUAL_HASH_64_LOOKUP2_DJB2_UNIT_DEFINES_SVH
`define DUAL_HASH_64_LOOKUP2_DJB2_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DHL_ASSERT_IMPLY(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, checked out of reset
`define DHL_ASSERT_NEXT(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[design/dhl_pkg.sv]
// types, constants and mix round function shared by the hash unit
package dhl_pkg;

	localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
	localparam logic [31:0] C_INIT   = 32'h000a8396;
	localparam logic [31:0] DJB_INIT = 32'h00001505;

	// bytes held before the twelfth byte of a block closes it
	localparam int BLOCK_HELD = 11;
	localparam logic [3:0] POS_FULL = 4'd11;

	localparam int MIX_ROUNDS = 9;
	localparam int unsigned MIX_SHIFT [0:MIX_ROUNDS-1] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

	typedef enum logic [1:0] {
		MIX_A,
		MIX_B,
		MIX_C
	} mix_role_t;

	typedef struct packed {
		logic        vld;
		logic        fin;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] djb;
	} mix_tok_t;

	// one round of the lookup2 mix: updates a single word
	function automatic mix_tok_t mix_round(input mix_tok_t t, input mix_role_t role,
			input int unsigned sh);
		mix_tok_t r;
		r = t;
		case (role)
			MIX_A: r.a = (t.a - t.b - t.c) ^ (t.c >> sh);
			MIX_B: r.b = (t.b - t.c - t.a) ^ (t.a << sh);
			default: r.c = (t.c - t.a - t.b) ^ (t.b >> sh);
		endcase
		return r;
	endfunction

endpackage

[design/dhl_mix_pipe.sv]
// lookup2 mix pipeline: an issue register, then nine stages of one round each
module dhl_mix_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  dhl_pkg::mix_tok_t          issue_tok,
	output dhl_pkg::mix_tok_t          exit_tok,
	output logic [dhl_pkg::MIX_ROUNDS:0] blk_map
);

	dhl_pkg::mix_tok_t tok_s [0:dhl_pkg::MIX_ROUNDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s[0] <= '0;
		end else if (adv) begin
			tok_s[0] <= issue_tok;
		end
	end

	for (genvar k = 1; k <= dhl_pkg::MIX_ROUNDS; k++) begin : g_round
		localparam dhl_pkg::mix_role_t ROLE = dhl_pkg::mix_role_t'((k - 1) % 3);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tok_s[k] <= '0;
			end else if (adv) begin
				tok_s[k] <= dhl_pkg::mix_round(tok_s[k-1], ROLE, dhl_pkg::MIX_SHIFT[k-1]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k <= dhl_pkg::MIX_ROUNDS; k++) begin
			blk_map[k] = tok_s[k].vld && !tok_s[k].fin;
		end
	end

	assign exit_tok = tok_s[dhl_pkg::MIX_ROUNDS];

endmodule

[design/dhl_absorb.sv]
// input register, byte absorption and block / final mix issue
module dhl_absorb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  logic              byte_valid,
	input  logic              last,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              adv,
	input  dhl_pkg::mix_tok_t wb_tok,
	output dhl_pkg::mix_tok_t issue_tok,
	output logic              mix_pend
);

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        bvld_s1;
	logic        last_s1;

	logic        byte_done_q;
	logic        mix_pend_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] c_q;
	logic [31:0] djb_q;
	logic [31:0] cnt_q;
	logic [3:0]  pos_q;
	logic [7:0]  held_q [0:dhl_pkg::BLOCK_HELD-1];

	logic        byte_part;
	logic        full_blk;
	logic        fin_ok;
	logic        proc;
	logic        store;
	logic        take_blk;
	logic        fire_fin;
	logic        done;
	logic        absorb;
	logic        wb_take;
	logic        accept;
	logic [31:0] djb_nx;
	logic [31:0] cnt_nx;
	logic [3:0]  n_tail;
	logic [7:0]  bb [0:dhl_pkg::BLOCK_HELD-1];
	logic [7:0]  tb [0:dhl_pkg::BLOCK_HELD-1];
	logic [31:0] wa;
	logic [31:0] wb;
	logic [31:0] wc;

	assign byte_part = bvld_s1 && !byte_done_q;
	assign full_blk  = byte_part && (pos_q == dhl_pkg::POS_FULL);
	assign fin_ok    = !full_blk && !mix_pend_q;
	assign proc      = vld_s1 && adv;
	assign store     = proc && byte_part && !full_blk;
	assign take_blk  = proc && full_blk && !mix_pend_q;
	assign fire_fin  = proc && last_s1 && fin_ok;
	assign done      = proc && (last_s1 ? fin_ok : (!full_blk || !mix_pend_q));
	assign absorb    = store || take_blk;
	assign wb_take   = adv && wb_tok.vld && !wb_tok.fin;

	assign item_stall = vld_s1 && !done;
	assign accept     = item_valid && !item_stall;

	// state as it stands once the byte of this request is taken in
	assign djb_nx = absorb ? ((djb_q << 5) + djb_q + {24'h0, byte_s1}) : djb_q;
	assign cnt_nx = cnt_q + {31'h0, absorb};
	assign n_tail = pos_q + {3'h0, store};

	always_comb begin
		for (int i = 0; i < dhl_pkg::BLOCK_HELD; i++) begin
			bb[i] = (store && pos_q == 4'(i)) ? byte_s1 : held_q[i];
			tb[i] = (4'(i) < n_tail) ? bb[i] : 8'h00;
		end
	end

	always_comb begin
		if (fire_fin) begin
			wa = {tb[3], tb[2], tb[1], tb[0]};
			wb = {tb[7], tb[6], tb[5], tb[4]};
			// tail of c starts at its second byte
			wc = {tb[10], tb[9], tb[8], 8'h00} + cnt_nx;
		end else begin
			wa = {held_q[3], held_q[2], held_q[1], held_q[0]};
			wb = {held_q[7], held_q[6], held_q[5], held_q[4]};
			wc = {byte_s1, held_q[10], held_q[9], held_q[8]};
		end
	end

	always_comb begin
		issue_tok.vld = take_blk || fire_fin;
		issue_tok.fin = fire_fin;
		issue_tok.a   = a_q + wa;
		issue_tok.b   = b_q + wb;
		issue_tok.c   = c_q + wc;
		issue_tok.djb = djb_nx;
	end

	assign mix_pend = mix_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (done) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			bvld_s1 <= byte_valid;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			held_q[pos_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_done_q <= 1'b0;
			mix_pend_q  <= 1'b0;
			a_q         <= dhl_pkg::GOLDEN;
			b_q         <= dhl_pkg::GOLDEN;
			c_q         <= dhl_pkg::C_INIT;
			djb_q       <= dhl_pkg::DJB_INIT;
			cnt_q       <= '0;
			pos_q       <= '0;
		end else begin
			if (done) begin
				byte_done_q <= 1'b0;
			end else if (absorb) begin
				byte_done_q <= 1'b1;
			end

			if (take_blk) begin
				mix_pend_q <= 1'b1;
			end else if (wb_take) begin
				mix_pend_q <= 1'b0;
			end

			if (wb_take) begin
				a_q <= wb_tok.a;
				b_q <= wb_tok.b;
				c_q <= wb_tok.c;
			end else if (fire_fin) begin
				a_q <= dhl_pkg::GOLDEN;
				b_q <= dhl_pkg::GOLDEN;
				c_q <= dhl_pkg::C_INIT;
			end

			if (fire_fin) begin
				djb_q <= dhl_pkg::DJB_INIT;
				cnt_q <= '0;
				pos_q <= '0;
			end else if (take_blk) begin
				djb_q <= djb_nx;
				cnt_q <= cnt_nx;
				pos_q <= '0;
			end else if (store) begin
				djb_q <= djb_nx;
				cnt_q <= cnt_nx;
				pos_q <= n_tail;
			end
		end
	end

endmodule

[design/dual_hash_64_lookup2_djb2_unit.sv]
// top level: dual lookup2 / djb2 message hash with output register
// path: a message end passes the input register, the mix issue register, the nine mix
// stages and the output register to hash_valid; one just after a full 12-byte block
// first waits for that block's mix; throughput: one request per cycle from the single
// absorb stage when not stalled; a message end that waits on a block mix holds the input
// reset: arst_n clears all control and restarts the hash state at its initial values
`include "dual_hash_64_lookup2_djb2_unit_defines.svh"

module dual_hash_64_lookup2_djb2_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	input  logic        item_valid,
	output logic        item_stall,
	output logic [63:0] hash_value,
	output logic        hash_valid,
	input  logic        hash_stall
);

	dhl_pkg::mix_tok_t             issue_tok;
	dhl_pkg::mix_tok_t             exit_tok;
	logic [dhl_pkg::MIX_ROUNDS:0]  blk_map;
	logic                          mix_pend;
	logic                          adv;
	logic                          fin_out;
	logic                          hash_valid_q;
	logic [63:0]                   hash_q;

	// a finished hash waiting on a stalled output freezes the mixer
	assign fin_out = exit_tok.vld && exit_tok.fin;
	assign adv     = !(fin_out && hash_valid_q && hash_stall);

	dhl_absorb u_absorb (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.adv        (adv),
		.wb_tok     (exit_tok),
		.issue_tok  (issue_tok),
		.mix_pend   (mix_pend)
	);

	dhl_mix_pipe u_mix_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.issue_tok (issue_tok),
		.exit_tok  (exit_tok),
		.blk_map   (blk_map)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if (fin_out && adv) begin
			hash_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			hash_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_out && adv) begin
			hash_q <= {exit_tok.djb, exit_tok.c};
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_value = hash_q;

	`DHL_ASSERT_IMPLY(a_blk_single, 1'b1, $countones(blk_map) <= 1, "two block mixes in flight")
	`DHL_ASSERT_IMPLY(a_pend_track, 1'b1, mix_pend == (blk_map != '0), "pend flag lost track")
	`DHL_ASSERT_IMPLY(a_fin_order, issue_tok.fin, !mix_pend, "final mix ahead of block mix")
	`DHL_ASSERT_NEXT(a_hold_keep, !adv, hash_valid && fin_out, "held result dropped")

endmodule

[tb/sv/testbench.sv]
// testbench for the dual lookup2 / djb2 hash unit: directed table, random messages, predictor
`timescale 1ns / 1ps

module testbench;

	localparam logic [31:0] LK_GOLDEN = 32'h9e3779b9;
	localparam logic [31:0] LK_C_SEED = 32'h000a8396;
	localparam logic [31:0] DJB_SEED  = 32'h00001505;
	localparam int TAIL_MAX     = 11;
	localparam int RANDOM_ITEMS = 620;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int DIR_ROWS     = 20;

	typedef struct packed {
		logic [7:0]  d;
		logic        bv;
		logic        lst;
		logic        typed;
		logic [31:0] djb;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        last = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [63:0] hash_value;
	logic        hash_valid;
	logic        hash_stall = 1'b0;

	// predictor state
	logic [31:0] lk_a, lk_b, lk_c;
	logic [7:0]  tail_bytes [0:TAIL_MAX-1];
	int          tail_fill;
	logic [31:0] msg_len;
	logic [31:0] djb_acc;

	logic [63:0] hash_expect_q [$];
	stim_row_t   dir_tab [0:DIR_ROWS-1];
	int          mismatches = 0;
	int          rx_hold = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;

	dual_hash_64_lookup2_djb2_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.byte_valid(byte_valid),
		.last      (last),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.hash_value(hash_value),
		.hash_valid(hash_valid),
		.hash_stall(hash_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void restart_message();
		lk_a = LK_GOLDEN;
		lk_b = LK_GOLDEN;
		lk_c = LK_C_SEED;
		tail_fill = 0;
		msg_len = 32'd0;
		djb_acc = DJB_SEED;
	endfunction

	function automatic void lookup2_mix();
		logic [31:0] a, b, c;
		a = lk_a;
		b = lk_b;
		c = lk_c;
		a = a - b - c; a = a ^ (c >> 13);
		b = b - c - a; b = b ^ (a << 8);
		c = c - a - b; c = c ^ (b >> 13);
		a = a - b - c; a = a ^ (c >> 12);
		b = b - c - a; b = b ^ (a << 16);
		c = c - a - b; c = c ^ (b >> 5);
		a = a - b - c; a = a ^ (c >> 3);
		b = b - c - a; b = b ^ (a << 10);
		c = c - a - b; c = c ^ (b >> 15);
		lk_a = a;
		lk_b = b;
		lk_c = c;
	endfunction

	// little-endian word of held bytes from base, only those below cnt
	function automatic logic [31:0] held_word(input int base, input int cnt);
		logic [31:0] w;
		int idx;
		w = 32'd0;
		for (int i = 0; i < 4; i++) begin
			idx = base + i;
			if (idx < cnt && idx < TAIL_MAX)
				w = w + ({24'h0, tail_bytes[idx]} << (8 * i));
		end
		return w;
	endfunction

	function automatic bit fold_request(input logic [7:0] d, input logic bv, input logic lst,
			output logic [63:0] h);
		logic [31:0] cpart;
		h = 64'd0;
		cpart = 32'd0;
		if (bv) begin
			djb_acc = {24'h0, d} + 32'd33 * djb_acc;
			msg_len = msg_len + 32'd1;
			if (tail_fill < TAIL_MAX) begin
				tail_bytes[tail_fill] = d;
				tail_fill++;
			end else begin
				// twelfth byte closes the block straight into c's top byte
				lk_a = lk_a + held_word(0, TAIL_MAX);
				lk_b = lk_b + held_word(4, TAIL_MAX);
				lk_c = lk_c + held_word(8, TAIL_MAX) + ({24'h0, d} << 24);
				lookup2_mix();
				tail_fill = 0;
			end
		end
		if (!lst)
			return 1'b0;
		lk_c = lk_c + msg_len;
		// c's share of the tail starts one byte up
		for (int i = 8; i < TAIL_MAX; i++)
			if (i < tail_fill)
				cpart = cpart + ({24'h0, tail_bytes[i]} << (8 * (i - 7)));
		lk_c = lk_c + cpart;
		lk_b = lk_b + held_word(4, tail_fill);
		lk_a = lk_a + held_word(0, tail_fill);
		lookup2_mix();
		h = {djb_acc, lk_c};
		restart_message();
		return 1'b1;
	endfunction

	// called just after a rising edge; returns just after the edge that accepts the request
	task automatic push_item(input logic [7:0] d, input logic bv, input logic lst,
			input logic typed, input logic [31:0] djb);
		int gap;
		logic [63:0] h;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_byte <= d;
		byte_valid <= bv;
		last <= lst;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (fold_request(d, bv, lst, h)) begin
			if (typed)
				h[63:32] = djb;
			hash_expect_q.push_back(h);
		end
	endtask

	always @(posedge clk) begin : hash_sink
		logic [63:0] want;
		if (arst_n) begin
			if (hash_valid && !hash_stall) begin
				if (hash_expect_q.size() == 0) begin
					flag_mismatch($sformatf("hash %h with none expected", hash_value));
				end else begin
					want = hash_expect_q.pop_front();
					if (hash_value !== want)
						flag_mismatch($sformatf("hash_value %h, want %h", hash_value, want));
				end
				rx_hold = calm ? 0 : $urandom_range(0, 8);
			end
			if (rx_hold > 0) begin
				hash_stall <= 1'b1;
				rx_hold--;
			end else begin
				hash_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (hash_valid && !hash_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles with no request or hash moving", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int items_sent;
		int msg_no;
		int sel;
		int len;
		bit end_apart;

		for (int i = 0; i < TAIL_MAX; i++)
			tail_bytes[i] = 8'h00;
		restart_message();

		// djb half typed where it is plain: 5381, then 33*5381 plus the byte
		dir_tab[0] = {8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_1505};
		dir_tab[1] = {8'ha5, 1'b0, 1'b0, 1'b0, 32'h0};
		dir_tab[2] = {8'h00, 1'b1, 1'b1, 1'b1, 32'h0002_b5a5};
		dir_tab[3] = {8'hff, 1'b1, 1'b1, 1'b1, 32'h0002_b6a4};
		// exactly one full block, so the tail at the end is empty
		for (int i = 0; i < 12; i++)
			dir_tab[4 + i] = {8'(i * 37 + 5), 1'b1, (i == 11), 1'b0, 32'h0};
		dir_tab[16] = {8'h80, 1'b1, 1'b0, 1'b0, 32'h0};
		dir_tab[17] = {8'h7f, 1'b1, 1'b0, 1'b0, 32'h0};
		dir_tab[18] = {8'h5a, 1'b0, 1'b0, 1'b0, 32'h0};
		dir_tab[19] = {8'hff, 1'b0, 1'b1, 1'b0, 32'h0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			push_item(dir_tab[r].d, dir_tab[r].bv, dir_tab[r].lst, dir_tab[r].typed,
				dir_tab[r].djb);

		items_sent = 0;
		msg_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			sel = $urandom_range(0, 9);
			case (sel)
				6, 7: len = 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
				8: len = $urandom_range(40, 120);
				9: len = 0;
				default: len = $urandom_range(0, 30);
			endcase
			end_apart = (len == 0) || ($urandom_range(0, 1) == 1);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					push_item(8'($urandom), 1'b0, 1'b0, 1'b0, 32'h0);
					items_sent++;
				end
				push_item(8'($urandom), 1'b1, (k == len - 1) && !end_apart, 1'b0, 32'h0);
				items_sent++;
			end
			if (end_apart) begin
				push_item(8'($urandom), 1'b0, 1'b1, 1'b0, 32'h0);
				items_sent++;
			end
			msg_no++;
			// every twelfth message, hold the requests back until every hash is out
			if (msg_no % 12 == 0) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (hash_expect_q.size() != 0)
					@(posedge clk);
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (hash_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
